### hdl/sfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfsc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_HEADER_FIRST  = 2'd1,
        REG_HEADER_SECOND = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [7:0] FRAME_LENGTH_RESET  = 8'd72;
    localparam logic [7:0] HEADER_FIRST_RESET  = 8'h5A;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'hA0;

    // Shortest frame the parser will collect
    localparam logic [7:0] MIN_FRAME_LEN = 8'd12;

    // Frame byte positions of the captured fields (big endian)
    localparam logic [7:0] POS_RANGE_HI = 8'd7;
    localparam logic [7:0] POS_RANGE_LO = 8'd8;
    localparam logic [7:0] POS_CONF_HI  = 8'd9;
    localparam logic [7:0] POS_CONF_LO  = 8'd10;

    // Current configuration as seen by the parser
    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] header_first;
        logic [7:0] header_second;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/sensor_frame_sync_checksum_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Sensor frame parser: finds a two-byte header in a byte stream, collects a
// fixed-length frame, checks its inverted 8-bit sum and reports range and
// confidence once per frame.
// Input channel s_*: one received byte per transfer in s_tdata[7:0].
// Output channel m_*: one transfer per frame, on its checksum byte.
//   m_tdata[15:0] range, m_tdata[31:16] confidence, m_tuser good flag.
// Config port: cfg_we with cfg_index 0 frame length, 1 first header byte,
//   2 second header byte; other indexes are ignored. Write only while idle.
// Throughput: one byte per cycle while no result is held, set by the parser
//   update between the input register and the result register.
// A result is registered: its checksum byte passes the input register, then the parser.
// Reset: registers return to length 72, header 0x5A 0xA0; the parser hunts
//   for a header and both channels are empty.
// Stall: a held result keeps its value; the input register still takes one
//   byte, bytes that give no result keep flowing only once the result leaves.
module sensor_frame_sync_checksum_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] range_mm, [31:16] confidence_value
    output logic             m_tuser,   // [0] frame_good
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    sfsc_pkg::cfg_t cfg;
    logic           in_valid;
    logic [7:0]     in_byte;
    logic           in_take;
    logic [15:0]    out_range;
    logic [15:0]    out_conf;

    sfsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfsc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take)
    );

    sfsc_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_take   (in_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_range (out_range),
        .out_conf  (out_conf),
        .out_good  (m_tuser)
    );

    assign m_tdata = {out_conf, out_range};

endmodule

`default_nettype wire

### hdl/sfsc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sfsc_cfg_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    output sfsc_pkg::cfg_t           cfg
);

    sfsc_pkg::cfg_t cfg_reg;

    // Register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_length  <= sfsc_pkg::FRAME_LENGTH_RESET;
            cfg_reg.header_first  <= sfsc_pkg::HEADER_FIRST_RESET;
            cfg_reg.header_second <= sfsc_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfsc_pkg::REG_FRAME_LENGTH:  cfg_reg.frame_length  <= cfg_data;
                sfsc_pkg::REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                sfsc_pkg::REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/sfsc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sfsc_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    output logic            in_valid,
    output logic [7:0]      in_byte,
    input  wire logic       in_take
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Refill whenever the held byte is empty or leaves this cycle
    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

`default_nettype wire

### hdl/sfsc_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfsc_parse_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sfsc_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    input  wire logic [7:0]      in_byte,
    output logic                 in_take,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [15:0]          out_range,
    output logic [15:0]          out_conf,
    output logic                 out_good
);

    typedef enum logic [1:0] {
        HUNT_FIRST  = 2'd0,
        HUNT_SECOND = 2'd1,
        COLLECT     = 2'd2
    } phase_t;

    phase_t      phase_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  sum_reg;
    logic [15:0] range_cap_reg;
    logic [15:0] conf_cap_reg;
    logic        out_valid_reg;
    logic [15:0] out_range_reg;
    logic [15:0] out_conf_reg;
    logic        out_good_reg;

    logic [7:0]  last_pos;

    // Position of the checksum byte, with short lengths clamped
    always_comb
    begin
        if (cfg.frame_length < sfsc_pkg::MIN_FRAME_LEN)
        begin
            last_pos = sfsc_pkg::MIN_FRAME_LEN - 8'd1;
        end
        else
        begin
            last_pos = cfg.frame_length - 8'd1;
        end
    end

    // A byte is consumed when the result slot is free or draining
    assign in_take = in_valid && (!out_valid_reg || out_ready);

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= HUNT_FIRST;
            pos_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            range_cap_reg <= 16'd0;
            conf_cap_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
            out_range_reg <= 16'd0;
            out_conf_reg  <= 16'd0;
            out_good_reg  <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_take)
            begin
                unique case (phase_reg)
                    HUNT_SECOND:
                    begin
                        if (in_byte == cfg.header_second)
                        begin
                            phase_reg <= COLLECT;
                            sum_reg   <= sum_reg + in_byte;
                            pos_reg   <= 8'd2;
                        end
                        else if (in_byte == cfg.header_first)
                        begin
                            // repeated first header byte restarts the header
                            phase_reg <= HUNT_SECOND;
                            pos_reg   <= 8'd1;
                            sum_reg   <= in_byte;
                        end
                        else
                        begin
                            phase_reg <= HUNT_FIRST;
                            pos_reg   <= 8'd0;
                            sum_reg   <= 8'd0;
                        end
                    end

                    COLLECT:
                    begin
                        if (pos_reg >= last_pos)
                        begin
                            // checksum byte: emit the frame, good or not
                            out_valid_reg <= 1'b1;
                            out_range_reg <= range_cap_reg;
                            out_conf_reg  <= conf_cap_reg;
                            out_good_reg  <= (~sum_reg == in_byte);
                            phase_reg     <= HUNT_FIRST;
                            pos_reg       <= 8'd0;
                            sum_reg       <= 8'd0;
                        end
                        else
                        begin
                            sum_reg <= sum_reg + in_byte;
                            if (pos_reg == sfsc_pkg::POS_RANGE_HI ||
                                pos_reg == sfsc_pkg::POS_RANGE_LO)
                            begin
                                range_cap_reg <= {range_cap_reg[7:0], in_byte};
                            end
                            else if (pos_reg == sfsc_pkg::POS_CONF_HI ||
                                     pos_reg == sfsc_pkg::POS_CONF_LO)
                            begin
                                conf_cap_reg <= {conf_cap_reg[7:0], in_byte};
                            end
                            pos_reg <= pos_reg + 8'd1;
                        end
                    end

                    default:
                    begin
                        // hunting for the first header byte, also the unused code
                        if (in_byte == cfg.header_first)
                        begin
                            phase_reg <= HUNT_SECOND;
                            pos_reg   <= 8'd1;
                            sum_reg   <= in_byte;
                        end
                        else
                        begin
                            phase_reg <= HUNT_FIRST;
                            pos_reg   <= 8'd0;
                            sum_reg   <= 8'd0;
                        end
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_range = out_range_reg;
    assign out_conf  = out_conf_reg;
    assign out_good  = out_good_reg;

endmodule

`default_nettype wire

### tb/sensor_frame_sync_checksum_parser_test.sv
`timescale 1ns / 1ps

module sensor_frame_sync_checksum_parser_test;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned IDLE_PERCENT   = 31;
    localparam int unsigned REPORT_DEPTH   = 16;
    // Index that no register answers to
    localparam logic [1:0]  REG_UNMAPPED   = 2'd3;

    // Parser position in the byte stream
    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        IN_FRAME
    } parse_phase_t;

    // One frame report as it leaves the block
    typedef struct packed {
        logic signed [15:0] range_mm;
        logic signed [15:0] confidence_value;
        logic               frame_good;
    } frame_report_t;

    typedef enum bit {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    // Directed row: a byte or a register write, with an optional known report
    typedef struct {
        row_kind_t     kind;
        logic [1:0]    index;
        logic [7:0]    value;
        bit            known;
        frame_report_t report;
    } directed_row_t;

    // Register setting and traffic shape of one random phase
    typedef struct {
        logic [7:0]  frame_len;
        logic [7:0]  first_hdr;
        logic [7:0]  second_hdr;
        int unsigned bytes;
        bit          quiet;
        bit          holdoff;
        bit          stray_write;
    } traffic_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'h00;

    // Shadow of the parser registers and state
    logic [7:0]   shadow_len;
    logic [7:0]   shadow_first;
    logic [7:0]   shadow_second;
    parse_phase_t parse_phase;
    logic [7:0]   frame_pos;
    logic [7:0]   frame_sum;
    logic [15:0]  range_cap;
    logic [15:0]  conf_cap;

    // Ring of reports still to come out, in order
    frame_report_t report_store [REPORT_DEPTH];
    int unsigned   reports_issued = 0;
    int unsigned   reports_checked = 0;
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   byte_budget = 0;
    bit            sender_idles = 1'b1;
    bit            receiver_idles = 1'b1;
    logic          holdoff_req = 1'b0;

    directed_row_t directed_rows [$] = '{
        '{ROW_CFG,  sfsc_pkg::REG_FRAME_LENGTH,  8'd0,  1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h5A, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h11, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h5A, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h5A, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hA0, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h80, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h7F, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h07, 1'b1, '{16'sh8000, 16'sh7FFF, 1'b1}},
        '{ROW_CFG,  sfsc_pkg::REG_HEADER_FIRST,  8'hFF, 1'b0, '0},
        '{ROW_CFG,  sfsc_pkg::REG_HEADER_SECOND, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'h00, 1'b0, '0},
        '{ROW_BYTE, 2'd0, 8'hFF, 1'b1, '{16'shFFFF, 16'sh0000, 1'b0}}
    };

    traffic_phase_t traffic_phases [$] = '{
        '{8'd12,  8'h5A, 8'hA0, 60,  1'b0, 1'b0, 1'b0},
        '{8'd12,  8'h5A, 8'hA0, 100, 1'b0, 1'b1, 1'b0},
        '{8'd255, 8'h00, 8'hFF, 300, 1'b0, 1'b0, 1'b0},
        '{8'd0,   8'hFF, 8'h00, 80,  1'b1, 1'b0, 1'b0},
        '{8'd13,  8'h5A, 8'h5A, 60,  1'b0, 1'b0, 1'b1},
        '{8'd31,  8'hC3, 8'h3C, 100, 1'b0, 1'b0, 1'b0}
    };

    sensor_frame_sync_checksum_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Advance the parser shadow by one accepted byte; flags a frame report
    function automatic void parse_byte(input logic [7:0] b, output bit done,
                                       output frame_report_t report);
        logic [7:0] eff_len;
        logic [7:0] want_sum;
        eff_len = (shadow_len < sfsc_pkg::MIN_FRAME_LEN) ? sfsc_pkg::MIN_FRAME_LEN
                                                          : shadow_len;
        done = 1'b0;
        report = '0;
        case (parse_phase)
            SEEK_SECOND:
            begin
                if (b == shadow_second)
                begin
                    parse_phase = IN_FRAME;
                    frame_sum = frame_sum + b;
                    frame_pos = 8'd2;
                end
                else if (b == shadow_first)
                begin
                    // repeated first header byte restarts the header
                    parse_phase = SEEK_SECOND;
                    frame_pos = 8'd1;
                    frame_sum = b;
                end
                else
                begin
                    parse_phase = SEEK_FIRST;
                    frame_pos = 8'd0;
                    frame_sum = 8'd0;
                end
            end
            IN_FRAME:
            begin
                if (frame_pos >= eff_len - 8'd1)
                begin
                    // checksum byte, also taken when the length shrank under us
                    want_sum = ~frame_sum;
                    done = 1'b1;
                    report = '{range_cap, conf_cap, want_sum == b};
                    parse_phase = SEEK_FIRST;
                    frame_pos = 8'd0;
                    frame_sum = 8'd0;
                end
                else
                begin
                    frame_sum = frame_sum + b;
                    if (frame_pos == sfsc_pkg::POS_RANGE_HI ||
                        frame_pos == sfsc_pkg::POS_RANGE_LO)
                        range_cap = {range_cap[7:0], b};
                    else if (frame_pos == sfsc_pkg::POS_CONF_HI ||
                             frame_pos == sfsc_pkg::POS_CONF_LO)
                        conf_cap = {conf_cap[7:0], b};
                    frame_pos = frame_pos + 8'd1;
                end
            end
            default:
            begin
                if (b == shadow_first)
                begin
                    parse_phase = SEEK_SECOND;
                    frame_pos = 8'd1;
                    frame_sum = b;
                end
                else
                begin
                    parse_phase = SEEK_FIRST;
                    frame_pos = 8'd0;
                    frame_sum = 8'd0;
                end
            end
        endcase
    endfunction

    // Offer one byte with random gaps and wait for its transfer
    task automatic send_byte(input logic [7:0] b, output bit done,
                             output frame_report_t report);
        while (sender_idles && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_byte(b, done, report);
        if (done)
        begin
            report_store[reports_issued % REPORT_DEPTH] = report;
            reports_issued++;
        end
    endtask

    // Byte within the current phase budget; extra bytes are dropped
    task automatic emit(input logic [7:0] b);
        bit            done;
        frame_report_t report;
        if (byte_budget != 0)
        begin
            send_byte(b, done, report);
            byte_budget--;
        end
    endtask

    // Stop offering and wait until every report is out and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_checked != reports_issued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            sfsc_pkg::REG_FRAME_LENGTH:  shadow_len = value;
            sfsc_pkg::REG_HEADER_FIRST:  shadow_first = value;
            sfsc_pkg::REG_HEADER_SECOND: shadow_second = value;
            default:                     ;
        endcase
    endtask

    // Mostly well-formed frames, some broken headers and plain noise
    task automatic send_random_burst();
        int unsigned pick;
        logic [7:0]  eff_len;
        logic [7:0]  sum;
        logic [7:0]  b;
        eff_len = (shadow_len < sfsc_pkg::MIN_FRAME_LEN) ? sfsc_pkg::MIN_FRAME_LEN
                                                          : shadow_len;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            repeat ($urandom_range(0, 2)) emit(8'($urandom));
            if ($urandom_range(0, 99) < 15)
                emit(shadow_first);
            sum = shadow_first + shadow_second;
            emit(shadow_first);
            emit(shadow_second);
            repeat (eff_len - 8'd3)
            begin
                b = 8'($urandom);
                sum = sum + b;
                emit(b);
            end
            b = ~sum;
            if ($urandom_range(0, 99) < 15)
                b = 8'($urandom);
            emit(b);
        end
        else if (pick < 88)
        begin
            emit(shadow_first);
            emit(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4)) emit(8'($urandom));
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_ready
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req <= 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            m_tready <= !(receiver_idles && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare every result transfer with the oldest pending report
    always @(posedge clk)
    begin : report_check
        frame_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reports_checked == reports_issued)
            begin
                error_count++;
                $display("%0t: unexpected report, got range %h conf %h good %b",
                         $time, m_tdata[15:0], m_tdata[31:16], m_tuser);
            end
            else
            begin
                want = report_store[reports_checked % REPORT_DEPTH];
                reports_checked++;
                if (m_tdata[15:0] !== want.range_mm)
                begin
                    error_count++;
                    $display("%0t: range_mm expected %h got %h",
                             $time, want.range_mm, m_tdata[15:0]);
                end
                if (m_tdata[31:16] !== want.confidence_value)
                begin
                    error_count++;
                    $display("%0t: confidence_value expected %h got %h",
                             $time, want.confidence_value, m_tdata[31:16]);
                end
                if (m_tuser !== want.frame_good)
                begin
                    error_count++;
                    $display("%0t: frame_good expected %b got %b",
                             $time, want.frame_good, m_tuser);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        bit            done;
        frame_report_t report;

        shadow_len    = sfsc_pkg::FRAME_LENGTH_RESET;
        shadow_first  = sfsc_pkg::HEADER_FIRST_RESET;
        shadow_second = sfsc_pkg::HEADER_SECOND_RESET;
        parse_phase   = SEEK_FIRST;
        frame_pos     = 8'd0;
        frame_sum     = 8'd0;
        range_cap     = 16'd0;
        conf_cap      = 16'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].index, directed_rows[i].value);
            else
            begin
                send_byte(directed_rows[i].value, done, report);
                if (directed_rows[i].known && (!done || report !== directed_rows[i].report))
                begin
                    error_count++;
                    $display("%0t: row %0d report expected %h got %h (done %b)",
                             $time, i, directed_rows[i].report, report, done);
                end
            end
        end

        // Random phases, each under its own register setting
        foreach (traffic_phases[p])
        begin
            if (traffic_phases[p].stray_write)
                write_reg(REG_UNMAPPED, 8'($urandom));
            write_reg(sfsc_pkg::REG_FRAME_LENGTH, traffic_phases[p].frame_len);
            write_reg(sfsc_pkg::REG_HEADER_FIRST, traffic_phases[p].first_hdr);
            write_reg(sfsc_pkg::REG_HEADER_SECOND, traffic_phases[p].second_hdr);
            sender_idles   = !traffic_phases[p].quiet;
            receiver_idles = !traffic_phases[p].quiet;
            if (traffic_phases[p].holdoff)
                holdoff_req <= 1'b1;
            byte_budget = traffic_phases[p].bytes;
            while (byte_budget != 0)
                send_random_burst();
        end

        settle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
